// ----- design/tdi_pkg.sv -----
`default_nettype none
package tdi_pkg;
    localparam int unsigned STAMP_W = 32;
    localparam int unsigned VALUE_W = 16;
    localparam int unsigned DELAY_W = 22;
    localparam int unsigned STEP_W  = 20;
    localparam int unsigned GAIN_W  = 16;
    localparam int unsigned DIV_W   = 32;

    localparam logic CFG_DELAY = 1'b0;
    localparam logic CFG_GAIN  = 1'b1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_LATCH_OLD,
        S_RD_NEWEST,
        S_RD_WAIT,
        S_CHECK,
        S_MULT,
        S_DIV_START,
        S_DIV,
        S_LERP,
        S_GAIN,
        S_SAT,
        S_OUT
    } t_state;

    typedef struct packed {
        logic write;      // push sample, advance time
        logic rd_newest;  // issue read of newest
        logic rd_older;   // issue read of next older
        logic latch_new;  // capture read as newer
        logic latch_old;  // capture read as older
        logic step_back;  // older becomes newer
        logic mult;
        logic div_start;
        logic lerp;
        logic gain;
        logic sat;
    } t_cmd;

    typedef struct packed {
        logic more;       // an older entry remains
        logic found;      // latched older is old enough
        logic short_span;
        logic div_busy;
    } t_sts;
endpackage
`default_nettype wire

// ----- design/tdi_ram.sv -----
`default_nettype none
module tdi_ram #(
    parameter int unsigned WIDTH = 16,
    parameter int unsigned DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

// ----- design/tdi_datapath.sv -----
`default_nettype none
module tdi_datapath #(
    parameter int unsigned RING_DEPTH = 64
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire tdi_pkg::t_cmd                i_cmd,
    output tdi_pkg::t_sts                     o_sts,
    input  wire logic [tdi_pkg::STEP_W-1:0]   i_step_us,
    input  wire logic signed [tdi_pkg::VALUE_W-1:0] i_steer_sample,
    input  wire logic                         i_restart,
    input  wire logic [tdi_pkg::DELAY_W-1:0]  i_delay_us,
    input  wire logic signed [tdi_pkg::GAIN_W-1:0]  i_yaw_gain,
    output logic signed [tdi_pkg::VALUE_W-1:0] o_delayed_steer,
    output logic signed [tdi_pkg::VALUE_W-1:0] o_yaw_target
);
    import tdi_pkg::*;

    localparam int unsigned AW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam int unsigned CW = $clog2(RING_DEPTH + 1);
    localparam logic [CW-1:0] FULL = CW'(RING_DEPTH);
    localparam logic [AW-1:0] LAST = AW'(RING_DEPTH - 1);
    localparam int unsigned PW = VALUE_W + 1 + STAMP_W;
    localparam int unsigned DCW = $clog2(PW + 1);

    logic [AW-1:0] r_slot, n_slot;
    logic [CW-1:0] r_count;
    logic [CW-1:0] r_left;
    logic [STAMP_W-1:0] r_time, n_time;
    logic [AW-1:0] r_raddr;
    logic [AW-1:0] w_raddr;
    logic [STAMP_W-1:0] w_stamp_rd;
    logic [VALUE_W-1:0] w_value_rd;

    logic [STAMP_W-1:0] r_age_new, r_age_old;
    logic signed [VALUE_W-1:0] r_val_new, r_val_old, r_result;
    logic [STAMP_W-1:0] w_age_rd;

    logic r_neg;
    logic [PW-1:0] r_prod;
    logic [PW-1:0] r_rem;
    logic [PW-1:0] r_quo;
    logic [STAMP_W-1:0] r_span;
    logic [DCW-1:0] r_div_cnt;
    logic signed [VALUE_W+GAIN_W:0] r_gp;
    logic signed [VALUE_W-1:0] r_dly, r_yaw;

    always_comb begin
        n_slot = (r_slot == LAST) ? '0 : r_slot + 1'b1;
        n_time = (i_restart ? '0 : r_time) + STAMP_W'(i_step_us);
    end

    // read address goes straight to the RAM, data is ready the next cycle
    always_comb begin
        w_raddr = r_raddr;
        if (i_cmd.rd_newest) begin
            w_raddr = (r_slot == '0) ? LAST : r_slot - 1'b1;
        end else if (i_cmd.rd_older || i_cmd.step_back) begin
            w_raddr = (r_raddr == '0) ? LAST : r_raddr - 1'b1;
        end
    end

    assign w_age_rd = r_time - w_stamp_rd;

    tdi_ram #(.WIDTH(STAMP_W), .DEPTH(RING_DEPTH)) u_stamp (
        .i_clk(i_clk), .i_we(i_cmd.write),
        .i_waddr(i_restart ? '0 : r_slot), .i_wdata(n_time),
        .i_raddr(w_raddr), .o_rdata(w_stamp_rd)
    );
    tdi_ram #(.WIDTH(VALUE_W), .DEPTH(RING_DEPTH)) u_value (
        .i_clk(i_clk), .i_we(i_cmd.write),
        .i_waddr(i_restart ? '0 : r_slot), .i_wdata(i_steer_sample),
        .i_raddr(w_raddr), .o_rdata(w_value_rd)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot    <= '0;
            r_count   <= '0;
            r_time    <= '0;
            r_div_cnt <= '0;
        end else begin
            if (i_cmd.write) begin
                r_time <= n_time;
                if (i_restart) begin
                    r_slot  <= (LAST == '0) ? '0 : AW'(1);
                    r_count <= CW'(1);
                end else begin
                    r_slot  <= n_slot;
                    r_count <= (r_count == FULL) ? FULL : r_count + 1'b1;
                end
            end
            if (i_cmd.div_start) begin
                r_div_cnt <= DCW'(PW);
            end else if (r_div_cnt != '0) begin
                r_div_cnt <= r_div_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_raddr <= w_raddr;
        if (i_cmd.rd_newest) begin
            r_left  <= r_count - 1'b1;
        end
        if (i_cmd.rd_older || i_cmd.step_back) begin
            r_left  <= r_left - 1'b1;
        end
        if (i_cmd.latch_new) begin
            r_age_new <= w_age_rd;
            r_val_new <= w_value_rd;
            r_result  <= w_value_rd;
        end
        if (i_cmd.latch_old) begin
            r_age_old <= w_age_rd;
            r_val_old <= w_value_rd;
            r_result  <= w_value_rd;
        end
        if (i_cmd.step_back) begin
            r_age_new <= r_age_old;
            r_val_new <= r_val_old;
        end
        if (i_cmd.mult) begin
            logic signed [VALUE_W:0] d;
            logic [VALUE_W:0] m;
            d = {r_val_new[VALUE_W-1], r_val_new} - {r_val_old[VALUE_W-1], r_val_old};
            m = d[VALUE_W] ? -d : d;
            r_neg  <= d[VALUE_W];
            r_prod <= PW'(m) * PW'(r_age_old - STAMP_W'(i_delay_us));
            r_span <= r_age_old - r_age_new;
        end
        if (i_cmd.div_start) begin
            r_rem <= '0;
            r_quo <= r_prod + PW'(r_span >> 1);
        end else if (r_div_cnt != '0) begin
            logic [PW:0] t;
            t = {r_rem, r_quo[PW-1]} - {{(PW+1-STAMP_W){1'b0}}, r_span};
            if (!t[PW]) begin
                r_rem <= t[PW-1:0];
                r_quo <= {r_quo[PW-2:0], 1'b1};
            end else begin
                r_rem <= {r_rem[PW-2:0], r_quo[PW-1]};
                r_quo <= {r_quo[PW-2:0], 1'b0};
            end
        end
        if (i_cmd.lerp) begin
            r_result <= r_neg ? r_val_old - VALUE_W'(r_quo)
                              : r_val_old + VALUE_W'(r_quo);
        end
        if (i_cmd.gain) begin
            r_gp <= r_result * i_yaw_gain;
        end
        if (i_cmd.sat) begin
            logic signed [VALUE_W+GAIN_W+1:0] s;
            logic signed [VALUE_W+GAIN_W-14:0] q;
            s = $signed({r_gp[VALUE_W+GAIN_W], r_gp}) + 16384;
            q = s[VALUE_W+GAIN_W+1:15];
            r_dly <= r_result;
            if (q > 32767) begin
                r_yaw <= 16'sh7FFF;
            end else if (q < -32768) begin
                r_yaw <= -16'sh8000;
            end else begin
                r_yaw <= q[VALUE_W-1:0];
            end
        end
    end

    always_comb begin
        o_sts.more       = (r_left != '0);
        o_sts.found      = (r_age_old >= STAMP_W'(i_delay_us));
        o_sts.short_span = ((r_age_old - r_age_new) <= STAMP_W'(1));
        o_sts.div_busy   = (r_div_cnt != '0);
    end

    assign o_delayed_steer = r_dly;
    assign o_yaw_target    = r_yaw;
endmodule
`default_nettype wire

// ----- design/tdi_ctrl.sv -----
`default_nettype none
module tdi_ctrl (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_in_valid,
    output logic                o_in_ready,
    output logic                o_out_load,
    input  wire logic           i_out_free,
    input  wire tdi_pkg::t_sts  i_sts,
    output tdi_pkg::t_cmd       o_cmd
);
    import tdi_pkg::*;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:      if (i_in_valid) n_state = S_RD_NEWEST;
            S_RD_NEWEST: n_state = S_RD_WAIT;
            S_RD_WAIT:   n_state = i_sts.more ? S_LATCH_OLD : S_GAIN;
            S_LATCH_OLD: n_state = S_CHECK;
            S_CHECK: begin
                if (i_sts.found) begin
                    n_state = i_sts.short_span ? S_GAIN : S_MULT;
                end else if (i_sts.more) begin
                    n_state = S_LATCH_OLD;
                end else begin
                    n_state = S_GAIN;
                end
            end
            S_MULT:      n_state = S_DIV_START;
            S_DIV_START: n_state = S_DIV;
            S_DIV:       if (!i_sts.div_busy) n_state = S_LERP;
            S_LERP:      n_state = S_GAIN;
            S_GAIN:      n_state = S_SAT;
            S_SAT:       n_state = S_OUT;
            S_OUT:       if (i_out_free) n_state = S_IDLE;
            default:     n_state = S_IDLE;
        endcase
    end

    // S_RD_WAIT: newest data ready; S_LATCH_OLD: next older data ready
    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        o_out_load = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.write = i_in_valid;
            end
            S_RD_NEWEST: o_cmd.rd_newest = 1'b1;
            S_RD_WAIT: begin
                o_cmd.latch_new = 1'b1;
                o_cmd.rd_older  = i_sts.more;
            end
            S_LATCH_OLD: o_cmd.latch_old = 1'b1;
            S_CHECK: begin
                if (!i_sts.found && i_sts.more) begin
                    o_cmd.step_back = 1'b1;
                end
            end
            S_MULT:      o_cmd.mult = 1'b1;
            S_DIV_START: o_cmd.div_start = 1'b1;
            S_DIV:       ;
            S_LERP:      o_cmd.lerp = 1'b1;
            S_GAIN:      o_cmd.gain = 1'b1;
            S_SAT:       o_cmd.sat = 1'b1;
            S_OUT:       o_out_load = i_out_free;
            default:     ;
        endcase
    end
endmodule
`default_nettype wire

// ----- design/timestamped_delay_interpolator_top.sv -----
// Time from accept to output word grows with k, the number of older entries walked
// (0 to RING_DEPTH-1), and with the bit-serial divide when interpolating.
// One word at a time: the next accept waits until the last word is loaded for output,
// which an output stall delays. The ring walk through the registered RAM read port
// and the divide set the time taken.
// Synchronous active-low reset clears time, slot, count and handshakes; RAMs are not cleared.
`default_nettype none
module timestamped_delay_interpolator_top #(
    parameter int unsigned RING_DEPTH = 64
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic        i_cfg_index,
    input  wire logic [21:0] i_cfg_data,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [39:0] s_axis_tdata,  // step_us[19:0], steer_sample[35:20]
    input  wire logic        s_axis_tuser,  // restart
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [31:0]      m_axis_tdata   // delayed_steer[15:0], yaw_target[31:16]
);
    import tdi_pkg::*;

    logic [DELAY_W-1:0] r_delay;
    logic signed [GAIN_W-1:0] r_gain;
    t_cmd w_cmd;
    t_sts w_sts;
    logic w_load;
    logic signed [VALUE_W-1:0] w_dly, w_yaw;
    logic r_valid;
    logic [31:0] r_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_delay <= '0;
            r_gain  <= '0;
            r_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_DELAY: r_delay <= i_cfg_data;
                    CFG_GAIN:  r_gain  <= i_cfg_data[GAIN_W-1:0];
                    default: ;
                endcase
            end
            if (w_load) begin
                r_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_data <= {w_yaw, w_dly};
        end
    end

    tdi_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(s_axis_tvalid), .o_in_ready(s_axis_tready),
        .o_out_load(w_load), .i_out_free(!r_valid || m_axis_tready),
        .i_sts(w_sts), .o_cmd(w_cmd)
    );

    tdi_datapath #(.RING_DEPTH(RING_DEPTH)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cmd(w_cmd), .o_sts(w_sts),
        .i_step_us(s_axis_tdata[19:0]),
        .i_steer_sample(s_axis_tdata[35:20]),
        .i_restart(s_axis_tuser),
        .i_delay_us(r_delay), .i_yaw_gain(r_gain),
        .o_delayed_steer(w_dly), .o_yaw_target(w_yaw)
    );

    assign m_axis_tvalid = r_valid;
    assign m_axis_tdata  = r_data;
endmodule
`default_nettype wire
